// ===== rtl/voxel_cube_frame_ops_core_defines.svh =====
// assertion macros shared by the voxel cube frame rtl
`ifndef VOXEL_CUBE_FRAME_OPS_CORE_DEFINES_SVH
`define VOXEL_CUBE_FRAME_OPS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define VCFO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define VCFO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define VCFO_ASSERT(lbl, prop, msg)
`define VCFO_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/vcfo_pkg.sv =====
// shared types and codes for the voxel cube frame operations core
package vcfo_pkg;

    typedef enum logic [3:0] {
        CMD_FILL       = 4'd0,
        CMD_COPY       = 4'd1,
        CMD_FWD        = 4'd2,
        CMD_BACK       = 4'd3,
        CMD_DOWN       = 4'd4,
        CMD_UP         = 4'd5,
        CMD_LEFT       = 4'd6,
        CMD_RIGHT      = 4'd7,
        CMD_COPY_LAYER = 4'd8,
        CMD_FILL_LAYER = 4'd9,
        CMD_CLR_LAYER  = 4'd10,
        CMD_MOVE       = 4'd11,
        CMD_WRITE      = 4'd12,
        CMD_READ       = 4'd13
    } vcfo_cmd_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } vcfo_axis_t;

    // command broadcast to every cell of the cube
    typedef struct packed {
        logic       en;
        vcfo_cmd_t  cmd;
        vcfo_axis_t axis;
        logic [1:0] source_layer;
        logic [1:0] target_layer;
        logic       move_up;
        logic       clear_vacated;
        logic [7:0] fill_value;
        logic [5:0] voxel_index;
    } vcfo_op_t;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 8;

endpackage

// ===== rtl/vcfo_cell.sv =====
// one voxel cell: holds the shown and next voxel and updates from its line neighbors
`include "voxel_cube_frame_ops_core_defines.svh"

module vcfo_cell
    import vcfo_pkg::*;
#(
    parameter int CUBE_SIDE  = 4,
    parameter int VOXEL_BITS = 8,
    parameter int CX         = 0,
    parameter int CY         = 0,
    parameter int CZ         = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vcfo_op_t              op,
    input  logic [VOXEL_BITS-1:0] line_shown [3][CUBE_SIDE],
    input  logic [VOXEL_BITS-1:0] line_next  [3][CUBE_SIDE],
    output logic [VOXEL_BITS-1:0] shown_value,
    output logic [VOXEL_BITS-1:0] next_value,
    output logic [VOXEL_BITS-1:0] rd_data
);

    localparam int INDEX = CX + CUBE_SIDE * CY + CUBE_SIDE * CUBE_SIDE * CZ;

    logic [VOXEL_BITS-1:0] shown_reg, shown_next;
    logic [VOXEL_BITS-1:0] next_reg, next_next;

    logic [VOXEL_BITS-1:0] shown_lo [3];
    logic [VOXEL_BITS-1:0] shown_hi [3];
    logic [VOXEL_BITS-1:0] next_lo  [3];
    logic [VOXEL_BITS-1:0] next_hi  [3];
    logic [VOXEL_BITS-1:0] layer_src [3];
    logic [2:0]            at_lo;
    logic [2:0]            at_hi;
    logic [2:0]            dst_hit;

    logic [15:0]           fill_wide;
    logic [VOXEL_BITS-1:0] fill_val;
    logic                  idx_hit;
    logic                  src_ok;

    // axis-selected views
    logic                  axis_ok;
    logic [VOXEL_BITS-1:0] sel_lo, sel_hi, sel_src;
    logic                  sel_at_lo, sel_at_hi, sel_dst;

    genvar a;
    for (a = 0; a < 3; a++) begin : g_axis
        localparam int C_A = (a == 0) ? CX : ((a == 1) ? CY : CZ);
        if (C_A > 0) begin : g_lo
            assign shown_lo[a] = line_shown[a][C_A-1];
            assign next_lo[a]  = line_next[a][C_A-1];
        end else begin : g_lo_edge
            assign shown_lo[a] = '0;
            assign next_lo[a]  = '0;
        end
        if (C_A < CUBE_SIDE - 1) begin : g_hi
            assign shown_hi[a] = line_shown[a][C_A+1];
            assign next_hi[a]  = line_next[a][C_A+1];
        end else begin : g_hi_edge
            assign shown_hi[a] = '0;
            assign next_hi[a]  = '0;
        end
        assign at_lo[a]   = (C_A == 0);
        assign at_hi[a]   = (C_A == CUBE_SIDE - 1);
        assign dst_hit[a] = (32'(op.target_layer) == C_A);
    end

    // same position in the source layer of each axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            layer_src[i] = '0;
            for (int k = 0; k < CUBE_SIDE; k++) begin
                if (32'(op.source_layer) == k) begin
                    layer_src[i] = line_next[i][k];
                end
            end
        end
    end

    assign fill_wide = {8'd0, op.fill_value};
    assign fill_val  = fill_wide[VOXEL_BITS-1:0];
    assign idx_hit   = (32'(op.voxel_index) == INDEX);
    assign src_ok    = (32'(op.source_layer) < CUBE_SIDE) &&
                       (op.source_layer != op.target_layer);

    always_comb begin
        axis_ok   = 1'b1;
        sel_lo    = next_lo[0];
        sel_hi    = next_hi[0];
        sel_src   = layer_src[0];
        sel_at_lo = at_lo[0];
        sel_at_hi = at_hi[0];
        sel_dst   = dst_hit[0];
        unique case (op.axis)
            AXIS_X: begin
                sel_lo    = next_lo[0];
                sel_hi    = next_hi[0];
                sel_src   = layer_src[0];
                sel_at_lo = at_lo[0];
                sel_at_hi = at_hi[0];
                sel_dst   = dst_hit[0];
            end
            AXIS_Y: begin
                sel_lo    = next_lo[1];
                sel_hi    = next_hi[1];
                sel_src   = layer_src[1];
                sel_at_lo = at_lo[1];
                sel_at_hi = at_hi[1];
                sel_dst   = dst_hit[1];
            end
            AXIS_Z: begin
                sel_lo    = next_lo[2];
                sel_hi    = next_hi[2];
                sel_src   = layer_src[2];
                sel_at_lo = at_lo[2];
                sel_at_hi = at_hi[2];
                sel_dst   = dst_hit[2];
            end
            default: begin
                axis_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        shown_next = shown_reg;
        next_next  = next_reg;
        if (op.en) begin
            unique case (op.cmd)
                CMD_FILL:  next_next = fill_val;
                CMD_COPY:  next_next = shown_reg;
                CMD_FWD:   next_next = shown_lo[1];
                CMD_BACK:  next_next = shown_hi[1];
                CMD_DOWN:  next_next = shown_hi[2];
                CMD_UP:    next_next = shown_lo[2];
                CMD_LEFT:  next_next = shown_hi[0];
                CMD_RIGHT: next_next = shown_lo[0];
                CMD_COPY_LAYER: begin
                    if (axis_ok && src_ok && sel_dst) begin
                        next_next = sel_src;
                    end
                end
                CMD_FILL_LAYER: begin
                    if (axis_ok && sel_dst) begin
                        next_next = VOXEL_BITS'(1);
                    end
                end
                CMD_CLR_LAYER: begin
                    if (axis_ok && sel_dst) begin
                        next_next = '0;
                    end
                end
                CMD_MOVE: begin
                    // end layer keeps a duplicate unless clear is asked for
                    if (axis_ok) begin
                        if (op.move_up) begin
                            if (!sel_at_lo) begin
                                next_next = sel_lo;
                            end else if (op.clear_vacated) begin
                                next_next = '0;
                            end
                        end else begin
                            if (!sel_at_hi) begin
                                next_next = sel_hi;
                            end else if (op.clear_vacated) begin
                                next_next = '0;
                            end
                        end
                    end
                end
                CMD_WRITE: begin
                    if (idx_hit) begin
                        shown_next = fill_val;
                    end
                end
                CMD_READ: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg <= '0;
            next_reg  <= '0;
        end else begin
            shown_reg <= shown_next;
            next_reg  <= next_next;
        end
    end

    assign shown_value = shown_reg;
    assign next_value  = next_reg;
    assign rd_data     = (op.cmd == CMD_READ && idx_hit) ? next_reg : '0;

    `VCFO_ASSERT(a_fill_lands, op.en && op.cmd == CMD_FILL |=> next_reg == $past(fill_val), "fill frame did not reach cell")
    `VCFO_ASSERT(a_idle_next_held, !op.en |=> next_reg == $past(next_reg), "next voxel moved while idle")
    `VCFO_ASSERT(a_shown_held, !(op.en && op.cmd == CMD_WRITE) |=> shown_reg == $past(shown_reg), "shown voxel moved without write")

endmodule

// ===== rtl/voxel_cube_frame_ops_core.sv =====
// Voxel cube frame operations core: a cube of voxel cells with a registered result stage.
// The result is registered and appears in m_tdata in the cycle after the input transaction.
// Throughput: one transaction per cycle while s_tready is high; every command reaches all cells in that cycle.
// s_tready drops only while a result waits and m_tready is low.
// Reset (synchronous, aresetn low) clears both frames and the pending result.
`include "voxel_cube_frame_ops_core_defines.svh"

module voxel_cube_frame_ops_core
    import vcfo_pkg::*;
#(
    parameter int CUBE_SIDE  = 4,
    parameter int VOXEL_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cmd[3:0], axis[5:4], source_layer[7:6], target_layer[9:8], move_up[10],
    // clear_vacated[11], fill_value[19:12], voxel_index[25:20], zero[31:26]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_data[7:0]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int VOXELS = CUBE_SIDE * CUBE_SIDE * CUBE_SIDE;

    vcfo_op_t              op;
    logic                  s_accept;
    logic [VOXEL_BITS-1:0] shown_q [VOXELS];
    logic [VOXEL_BITS-1:0] next_q  [VOXELS];
    logic [VOXEL_BITS-1:0] rd_q    [VOXELS];
    logic [VOXEL_BITS-1:0] rd_any;
    logic [15:0]           rd_wide;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign op.en            = s_accept;
    assign op.cmd           = vcfo_cmd_t'(s_tdata[3:0]);
    assign op.axis          = vcfo_axis_t'(s_tdata[5:4]);
    assign op.source_layer  = s_tdata[7:6];
    assign op.target_layer  = s_tdata[9:8];
    assign op.move_up       = s_tdata[10];
    assign op.clear_vacated = s_tdata[11];
    assign op.fill_value    = s_tdata[19:12];
    assign op.voxel_index   = s_tdata[25:20];

    genvar gx, gy, gz, gk;
    for (gz = 0; gz < CUBE_SIDE; gz++) begin : g_z
        for (gy = 0; gy < CUBE_SIDE; gy++) begin : g_y
            for (gx = 0; gx < CUBE_SIDE; gx++) begin : g_x
                localparam int V = gx + CUBE_SIDE * gy + CUBE_SIDE * CUBE_SIDE * gz;
                logic [VOXEL_BITS-1:0] ls [3][CUBE_SIDE];
                logic [VOXEL_BITS-1:0] ln [3][CUBE_SIDE];

                // lines through this cell along x, y and z
                for (gk = 0; gk < CUBE_SIDE; gk++) begin : g_line
                    localparam int IX = gk + CUBE_SIDE * gy + CUBE_SIDE * CUBE_SIDE * gz;
                    localparam int IY = gx + CUBE_SIDE * gk + CUBE_SIDE * CUBE_SIDE * gz;
                    localparam int IZ = gx + CUBE_SIDE * gy + CUBE_SIDE * CUBE_SIDE * gk;
                    assign ls[0][gk] = shown_q[IX];
                    assign ls[1][gk] = shown_q[IY];
                    assign ls[2][gk] = shown_q[IZ];
                    assign ln[0][gk] = next_q[IX];
                    assign ln[1][gk] = next_q[IY];
                    assign ln[2][gk] = next_q[IZ];
                end

                vcfo_cell #(
                    .CUBE_SIDE  (CUBE_SIDE),
                    .VOXEL_BITS (VOXEL_BITS),
                    .CX         (gx),
                    .CY         (gy),
                    .CZ         (gz)
                ) u_cell (
                    .aclk        (aclk),
                    .aresetn     (aresetn),
                    .op          (op),
                    .line_shown  (ls),
                    .line_next   (ln),
                    .shown_value (shown_q[V]),
                    .next_value  (next_q[V]),
                    .rd_data     (rd_q[V])
                );
            end
        end
    end

    // at most one cell answers a read, the rest drive zero
    always_comb begin
        rd_any = '0;
        for (int i = 0; i < VOXELS; i++) begin
            rd_any = rd_any | rd_q[i];
        end
    end

    assign rd_wide = 16'(rd_any);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (s_accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = rd_wide[OUT_DATA_W-1:0];
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `VCFO_ASSERT_ALWAYS(a_reset_no_result, !aresetn |=> !m_tvalid, "result valid right after reset")
    `VCFO_ASSERT(a_accept_gives_result, s_accept |=> m_tvalid, "accepted transaction left no result")
    `VCFO_ASSERT(a_non_read_zero, s_accept && op.cmd != CMD_READ |=> m_tdata == '0, "non-read command returned nonzero data")

endmodule
